### rtl/jdn_pkg.sv
package jdn_pkg;

	// Number of register stages from request to result.
	localparam int NumStages = 8;

	localparam logic OpDateToNum = 1'b0;
	localparam logic OpNumToDate = 1'b1;

	localparam logic [13:0] YearMin     = 14'd1;
	localparam logic [13:0] YearMax     = 14'd9999;
	localparam logic [3:0]  MonthMin    = 4'd1;
	localparam logic [3:0]  MonthMax    = 4'd12;
	localparam logic [22:0] DayNumMin   = 23'd1721424;
	localparam logic [22:0] DayNumMax   = 23'd5373484;

	// First Gregorian date and the last day number before it (the last Julian day).
	localparam logic [13:0] ReformYear      = 14'd1582;
	localparam logic [3:0]  ReformMonth     = 4'd10;
	localparam logic [4:0]  ReformDay       = 5'd15;
	localparam logic [22:0] ReformDayNumber = 23'd2299160;

	localparam logic [24:0] DateOffset = 25'd1720995;
	localparam logic [24:0] GregOffset = 25'd7468865;
	localparam logic [22:0] EpochShift = 23'd1524;
	localparam logic [26:0] YearOffset = 27'd2442;
	localparam logic [13:0] YearBaseLate  = 14'd4716;
	localparam logic [13:0] YearBaseEarly = 14'd4715;

	// Reciprocals for exact floor division of bounded operands:
	// floor(x / D) == (x * ceil(2^s / D)) >> s for x < 2^(s - ceil(log2 D)).
	localparam logic [6:0]  CentShift = 7'd19;
	localparam logic [12:0] CentRecip = 13'd5243;
	localparam logic [24:0] GregRecip =
		25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
	localparam logic [27:0] YearRecip =
		28'(((64'd1 << 40) + 64'd7304) / 64'd7305);
	localparam logic [24:0] MonthRecip =
		25'((((64'd1 << 29) * 64'd10000) + 64'd306000) / 64'd306001);

	// floor(30.6001 * k) for the month counts that can occur.
	function automatic logic [8:0] floor_30_6001(input logic [4:0] k);
		logic [8:0] r;
		case (k)
			5'd1:    r = 9'd30;
			5'd2:    r = 9'd61;
			5'd3:    r = 9'd91;
			5'd4:    r = 9'd122;
			5'd5:    r = 9'd153;
			5'd6:    r = 9'd183;
			5'd7:    r = 9'd214;
			5'd8:    r = 9'd244;
			5'd9:    r = 9'd275;
			5'd10:   r = 9'd306;
			5'd11:   r = 9'd336;
			5'd12:   r = 9'd367;
			5'd13:   r = 9'd397;
			5'd14:   r = 9'd428;
			5'd15:   r = 9'd459;
			5'd16:   r = 9'd489;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/jdn_req_if.sv
interface jdn_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [22:0] day_number;

	modport source (output valid, opcode, year, month, day_of_month, day_number,
		input ready);
	modport sink (input valid, opcode, year, month, day_of_month, day_number,
		output ready);
endinterface

### rtl/jdn_res_if.sv
interface jdn_res_if;
	logic        valid;
	logic        ready;
	logic [22:0] out_day_number;
	logic [13:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic        bad_input;

	modport source (output valid, out_day_number, out_year, out_month, out_day,
		bad_input, input ready);
	modport sink (input valid, out_day_number, out_year, out_month, out_day,
		bad_input, output ready);
endinterface

### rtl/julian_day_number_converter.sv
// Channel | Dir | Fields                                              | Meaning
// req     | in  | opcode, year, month, day_of_month, day_number      | one conversion request
// res     | out | out_day_number, out_year, out_month, out_day,      | one result per request
//         |     | bad_input                                           |
//
// Each accepted request passes through the eight-stage register pipeline to its
// result; a new request can be taken every cycle unless all stages are full and stalled.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage holds while the next one is full and blocked, so a stalled result
// waits in the last stage and empty stages upstream still fill.
module julian_day_number_converter (
	input logic          clk,
	input logic          arst_n,
	jdn_req_if.sink      req,
	jdn_res_if.source    res
);

	localparam int N = jdn_pkg::NumStages;

	logic [N-1:0] en;
	logic [N-1:0] vld_s;
	logic [N-1:0] op_s;
	logic [N-1:0] bad_s;
	logic         bad_in;

	logic [22:0]  d2n_dn;
	logic [13:0]  n2d_year;
	logic [3:0]   n2d_month;
	logic [4:0]   n2d_day;

	// A stage loads when it is empty or its contents move on this cycle.
	always_comb begin
		en[N-1] = !vld_s[N-1] || res.ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign req.ready = en[0];

	always_comb begin
		if (req.opcode == jdn_pkg::OpDateToNum) begin
			bad_in = (req.year < jdn_pkg::YearMin) || (req.year > jdn_pkg::YearMax) ||
				(req.month < jdn_pkg::MonthMin) || (req.month > jdn_pkg::MonthMax) ||
				(req.day_of_month == 5'd0);
		end else begin
			bad_in = (req.day_number < jdn_pkg::DayNumMin) ||
				(req.day_number > jdn_pkg::DayNumMax);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= req.valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s[0]  <= req.opcode;
			bad_s[0] <= bad_in;
		end
		for (int k = 1; k < N; k++) begin
			if (en[k]) begin
				op_s[k]  <= op_s[k-1];
				bad_s[k] <= bad_s[k-1];
			end
		end
	end

	jdn_d2n u_d2n (
		.clk          (clk),
		.en           (en),
		.year         (req.year),
		.month        (req.month),
		.day_of_month (req.day_of_month),
		.day_number   (d2n_dn)
	);

	jdn_n2d u_n2d (
		.clk        (clk),
		.en         (en),
		.day_number (req.day_number),
		.year       (n2d_year),
		.month      (n2d_month),
		.day        (n2d_day)
	);

	assign res.valid     = vld_s[N-1];
	assign res.bad_input = bad_s[N-1];
	assign res.out_day_number =
		(!bad_s[N-1] && (op_s[N-1] == jdn_pkg::OpDateToNum)) ? d2n_dn : 23'd0;
	assign res.out_year  =
		(!bad_s[N-1] && (op_s[N-1] == jdn_pkg::OpNumToDate)) ? n2d_year : 14'd0;
	assign res.out_month =
		(!bad_s[N-1] && (op_s[N-1] == jdn_pkg::OpNumToDate)) ? n2d_month : 4'd0;
	assign res.out_day   =
		(!bad_s[N-1] && (op_s[N-1] == jdn_pkg::OpNumToDate)) ? n2d_day : 5'd0;

	// An empty output stage never holds back new requests.
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> req.ready)
		else $error("request refused while the output stage is empty");

	// With the sink ready the whole pipeline moves.
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res.ready |-> req.ready)
		else $error("pipeline stalled although the result is being taken");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.bad_input) |-> (res.out_day_number == 23'd0) &&
		(res.out_year == 14'd0) && (res.out_month == 4'd0) && (res.out_day == 5'd0))
		else $error("rejected request returned nonzero fields");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.bad_input && (op_s[N-1] == jdn_pkg::OpNumToDate)) |->
		(res.out_month >= 4'd1) && (res.out_month <= 4'd12) && (res.out_day != 5'd0))
		else $error("converted date has an impossible month or day");

endmodule

### rtl/jdn_d2n.sv
module jdn_d2n (
	input  logic                           clk,
	input  logic [jdn_pkg::NumStages-1:0]  en,
	input  logic [13:0]                    year,
	input  logic [3:0]                     month,
	input  logic [4:0]                     day_of_month,
	output logic [22:0]                    day_number
);

	localparam int N = jdn_pkg::NumStages;

	logic [13:0] y_in;
	logic [3:0]  m_in;
	logic        greg_in;

	logic [13:0] y_s1;
	logic [3:0]  m_s1;
	logic [4:0]  dd_s1;
	logic        greg_s1;

	logic [26:0] cent_prod;
	logic [24:0] quad_prod;
	logic [6:0]  cent;
	logic [8:0]  b_in;

	logic [8:0]  b_s2;
	logic [21:0] q_s2;
	logic [8:0]  mt_s2;
	logic [4:0]  dd_s2;

	logic [24:0] sum;
	logic [22:0] dn_s3;
	logic [22:0] dn_dly_s [3:N-1];

	// January and February count as months 13 and 14 of the previous year.
	always_comb begin
		if (month <= 4'd2) begin
			y_in = year - 14'd1;
			m_in = month + 4'd12;
		end else begin
			y_in = year;
			m_in = month;
		end
		greg_in = (y_in > jdn_pkg::ReformYear) ||
			((y_in == jdn_pkg::ReformYear) && ((m_in > jdn_pkg::ReformMonth) ||
			((m_in == jdn_pkg::ReformMonth) && (day_of_month >= jdn_pkg::ReformDay))));
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			y_s1    <= y_in;
			m_s1    <= m_in;
			dd_s1   <= day_of_month;
			greg_s1 <= greg_in;
		end
	end

	always_comb begin
		cent_prod = 27'(y_s1) * 27'(jdn_pkg::CentRecip);
		cent      = cent_prod[25:19];
		quad_prod = 25'(y_s1) * 25'd1461;
		b_in      = greg_s1 ? (9'd2 - {2'b00, cent} + {4'b0000, cent[6:2]}) : 9'd0;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			b_s2  <= b_in;
			q_s2  <= quad_prod[23:2];
			mt_s2 <= jdn_pkg::floor_30_6001({1'b0, m_s1} + 5'd1);
			dd_s2 <= dd_s1;
		end
	end

	assign sum = {3'b000, q_s2} + {16'b0, mt_s2} + {20'b0, dd_s2}
		+ jdn_pkg::DateOffset + {{16{b_s2[8]}}, b_s2};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dn_s3 <= sum[22:0];
		end
		if (en[3]) begin
			dn_dly_s[3] <= dn_s3;
		end
		for (int k = 4; k < N; k++) begin
			if (en[k]) begin
				dn_dly_s[k] <= dn_dly_s[k-1];
			end
		end
	end

	assign day_number = dn_dly_s[N-1];

endmodule

### rtl/jdn_n2d.sv
module jdn_n2d (
	input  logic                           clk,
	input  logic [jdn_pkg::NumStages-1:0]  en,
	input  logic [22:0]                    day_number,
	output logic [13:0]                    year,
	output logic [3:0]                     month,
	output logic [4:0]                     day
);

	logic        greg_in;
	logic [24:0] x_full;

	logic [22:0] z_s1;
	logic        greg_s1;
	logic [23:0] x_s1;

	logic [48:0] p1;
	logic [22:0] z_s2;
	logic        greg_s2;
	logic [6:0]  a_s2;

	logic [22:0] c_in;
	logic [22:0] c_s3;

	logic [26:0] t_in;
	logic [26:0] t_s4;
	logic [8:0]  c_s4;

	logic [54:0] p2;
	logic [13:0] d_s5;
	logic [8:0]  c_s5;

	logic [24:0] p3;
	logic [8:0]  e_s6;
	logic [13:0] d_s6;
	logic [8:0]  c_s6;

	logic [8:0]  w_in;
	logic [33:0] p4;
	logic [4:0]  g_s7;
	logic [8:0]  w_s7;
	logic [13:0] d_s7;

	logic [8:0]  day_full;
	logic [4:0]  mon_full;
	logic [3:0]  mon_in;
	logic [13:0] year_in;

	logic [13:0] year_s8;
	logic [3:0]  month_s8;
	logic [4:0]  day_s8;

	assign greg_in = day_number > jdn_pkg::ReformDayNumber;
	assign x_full  = {day_number, 2'b00} - jdn_pkg::GregOffset;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_s1    <= day_number;
			greg_s1 <= greg_in;
			x_s1    <= greg_in ? x_full[23:0] : 24'd0;
		end
	end

	// Number of Gregorian centuries since the epoch.
	assign p1 = 49'(x_s1) * 49'(jdn_pkg::GregRecip);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			z_s2    <= z_s1;
			greg_s2 <= greg_s1;
			a_s2    <= p1[48:42];
		end
	end

	assign c_in = greg_s2
		? (z_s2 + 23'd1 + {16'b0, a_s2} - {18'b0, a_s2[6:2]} + jdn_pkg::EpochShift)
		: (z_s2 + jdn_pkg::EpochShift);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			c_s3 <= c_in;
		end
	end

	assign t_in = {c_s3, 4'b0000} + {2'b00, c_s3, 2'b00} - jdn_pkg::YearOffset;

	// Only the low bits of c matter below: the day within the year is under 512.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			t_s4 <= t_in;
			c_s4 <= c_s3[8:0];
		end
	end

	assign p2 = 55'(t_s4) * 55'(jdn_pkg::YearRecip);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			d_s5 <= p2[53:40];
			c_s5 <= c_s4;
		end
	end

	assign p3 = 25'(d_s5) * 25'd1461;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			e_s6 <= p3[10:2];
			d_s6 <= d_s5;
			c_s6 <= c_s5;
		end
	end

	assign w_in = c_s6 - e_s6;
	assign p4   = 34'(w_in) * 34'(jdn_pkg::MonthRecip);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			g_s7 <= p4[33:29];
			w_s7 <= w_in;
			d_s7 <= d_s6;
		end
	end

	always_comb begin
		day_full = w_s7 - jdn_pkg::floor_30_6001(g_s7);
		mon_full = (g_s7 < 5'd14) ? (g_s7 - 5'd1) : (g_s7 - 5'd13);
		mon_in   = mon_full[3:0];
		year_in  = (mon_in > 4'd2) ? (d_s7 - jdn_pkg::YearBaseLate)
			: (d_s7 - jdn_pkg::YearBaseEarly);
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			year_s8  <= year_in;
			month_s8 <= mon_in;
			day_s8   <= day_full[4:0];
		end
	end

	assign year  = year_s8;
	assign month = month_s8;
	assign day   = day_s8;

endmodule
